>>> rtl/atc_pkg.sv
package atc_pkg;

	localparam int RAW_W   = 16;
	localparam int CFG_W   = 15;
	localparam int IDX_W   = 3;
	localparam int DZ_W    = 15;
	localparam int ALPHA_W = 9;
	localparam int LIM_W   = 15;
	localparam int DEV_W   = RAW_W + 1;
	localparam int V_W     = 16;
	localparam int FILT_W  = 18;
	localparam int ACC_W   = 28;
	localparam int DIV_N_W = 32;
	localparam int DIV_D_W = DEV_W;
	localparam int QUO_W   = 16;
	localparam int PC_W    = 5;

	localparam int CAL_SAMPLES_DEF = 64;
	localparam int ONE_G           = 16384;
	localparam int PITCH_K         = 11520;  // 45 deg in Q8
	localparam int ALPHA_ONE       = 256;
	localparam int Q8_SHIFT        = 8;
	localparam int Q8_HALF         = 128;
	localparam int Q2_SHIFT        = 2;
	localparam int Q2_HALF         = 2;

	localparam logic [DZ_W-1:0]    DZ_RST    = DZ_W'(328);
	localparam logic [ALPHA_W-1:0] ALPHA_RST = ALPHA_W'(77);
	localparam logic [LIM_W-1:0]   LIM_RST   = LIM_W'(20480);

	localparam logic [1:0] REQ_CAL   = 2'd0;
	localparam logic [1:0] REQ_TILT  = 2'd1;
	localparam logic [1:0] REQ_PITCH = 2'd2;

	typedef enum logic [IDX_W-1:0] {
		REG_SENSOR_READY,
		REG_DEAD_ZONE,
		REG_SMOOTH_ALPHA,
		REG_FLIP_X,
		REG_FLIP_Y,
		REG_PITCH_LIMIT
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]              req_type;
		logic signed [RAW_W-1:0] raw_x;
		logic signed [RAW_W-1:0] raw_y;
		logic signed [RAW_W-1:0] raw_z;
		logic                    read_ok;
	} in_item_t;

	typedef struct packed {
		logic signed [V_W-1:0] tilt_x;
		logic signed [V_W-1:0] tilt_y;
		logic signed [V_W-1:0] pitch_angle;
		logic                  calib_done;
	} out_item_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_WAIT,
		OP_CAL_ACC,
		OP_DIV_LOAD,
		OP_DIV_STEP,
		OP_SET_OFF,
		OP_DEV,
		OP_DZ,
		OP_MUL_F,
		OP_MUL_ACC,
		OP_F_UPD,
		OP_TILT_OUT,
		OP_PMUL,
		OP_PCLAMP,
		OP_EMIT
	} op_t;

	typedef enum logic [2:0] {
		C_NEXT,
		C_ALWAYS,
		C_DISPATCH,
		C_DIV_MORE,
		C_CAL_OPEN,
		C_PITCH_SKIP
	} cond_t;

	typedef enum logic [1:0] {
		SEL_X,
		SEL_Y,
		SEL_Z,
		SEL_P
	} sel_t;

	typedef struct packed {
		op_t             op;
		sel_t            sel;
		cond_t           cond;
		logic [PC_W-1:0] target;
	} cw_t;

	typedef struct packed {
		logic load;
		logic step;
	} div_ctl_t;

	typedef struct packed {
		logic             more;
		logic             neg;
		logic             ovf;
		logic [QUO_W-1:0] quo;
	} div_stat_t;

	localparam logic [PC_W-1:0] PC_IDLE  = PC_W'(0);
	localparam logic [PC_W-1:0] PC_CAL   = PC_W'(1);
	localparam logic [PC_W-1:0] PC_TILT  = PC_W'(11);
	localparam logic [PC_W-1:0] PC_PITCH = PC_W'(23);
	localparam logic [PC_W-1:0] PC_EMIT  = PC_W'(28);

	function automatic cw_t mk(op_t op, sel_t sel, cond_t cond, logic [PC_W-1:0] target);
		cw_t w;
		w.op     = op;
		w.sel    = sel;
		w.cond   = cond;
		w.target = target;
		return w;
	endfunction

	// microprogram; a taken jump goes to target, otherwise to the next step
	function automatic cw_t ucode(logic [PC_W-1:0] pc);
		cw_t w;
		unique case (pc)
			PC_W'(0):  w = mk(OP_WAIT,     SEL_X, C_DISPATCH,   PC_IDLE);
			// calibration
			PC_W'(1):  w = mk(OP_CAL_ACC,  SEL_X, C_CAL_OPEN,   PC_EMIT);
			PC_W'(2):  w = mk(OP_DIV_LOAD, SEL_X, C_NEXT,       PC_IDLE);
			PC_W'(3):  w = mk(OP_DIV_STEP, SEL_X, C_DIV_MORE,   PC_W'(3));
			PC_W'(4):  w = mk(OP_SET_OFF,  SEL_X, C_NEXT,       PC_IDLE);
			PC_W'(5):  w = mk(OP_DIV_LOAD, SEL_Y, C_NEXT,       PC_IDLE);
			PC_W'(6):  w = mk(OP_DIV_STEP, SEL_Y, C_DIV_MORE,   PC_W'(6));
			PC_W'(7):  w = mk(OP_SET_OFF,  SEL_Y, C_NEXT,       PC_IDLE);
			PC_W'(8):  w = mk(OP_DIV_LOAD, SEL_Z, C_NEXT,       PC_IDLE);
			PC_W'(9):  w = mk(OP_DIV_STEP, SEL_Z, C_DIV_MORE,   PC_W'(9));
			PC_W'(10): w = mk(OP_SET_OFF,  SEL_Z, C_ALWAYS,     PC_EMIT);
			// tilt
			PC_W'(11): w = mk(OP_DEV,      SEL_X, C_NEXT,       PC_IDLE);
			PC_W'(12): w = mk(OP_DZ,       SEL_X, C_NEXT,       PC_IDLE);
			PC_W'(13): w = mk(OP_MUL_F,    SEL_X, C_NEXT,       PC_IDLE);
			PC_W'(14): w = mk(OP_MUL_ACC,  SEL_X, C_NEXT,       PC_IDLE);
			PC_W'(15): w = mk(OP_F_UPD,    SEL_X, C_NEXT,       PC_IDLE);
			PC_W'(16): w = mk(OP_TILT_OUT, SEL_X, C_NEXT,       PC_IDLE);
			PC_W'(17): w = mk(OP_DEV,      SEL_Y, C_NEXT,       PC_IDLE);
			PC_W'(18): w = mk(OP_DZ,       SEL_Y, C_NEXT,       PC_IDLE);
			PC_W'(19): w = mk(OP_MUL_F,    SEL_Y, C_NEXT,       PC_IDLE);
			PC_W'(20): w = mk(OP_MUL_ACC,  SEL_Y, C_NEXT,       PC_IDLE);
			PC_W'(21): w = mk(OP_F_UPD,    SEL_Y, C_NEXT,       PC_IDLE);
			PC_W'(22): w = mk(OP_TILT_OUT, SEL_Y, C_ALWAYS,     PC_EMIT);
			// pitch
			PC_W'(23): w = mk(OP_DEV,      SEL_P, C_NEXT,       PC_IDLE);
			PC_W'(24): w = mk(OP_PMUL,     SEL_P, C_PITCH_SKIP, PC_EMIT);
			PC_W'(25): w = mk(OP_DIV_LOAD, SEL_P, C_NEXT,       PC_IDLE);
			PC_W'(26): w = mk(OP_DIV_STEP, SEL_P, C_DIV_MORE,   PC_W'(26));
			PC_W'(27): w = mk(OP_PCLAMP,   SEL_P, C_NEXT,       PC_IDLE);
			PC_W'(28): w = mk(OP_EMIT,     SEL_X, C_ALWAYS,     PC_IDLE);
			default:   w = mk(OP_NOP,      SEL_X, C_ALWAYS,     PC_IDLE);
		endcase
		return w;
	endfunction

endpackage

>>> rtl/atc_div.sv
// signed divide, truncating toward zero; one quotient bit per step, MSB first
module atc_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  atc_pkg::div_ctl_t                   ctl,
	input  logic signed [atc_pkg::DIV_N_W-1:0]  num,
	input  logic signed [atc_pkg::DIV_D_W-1:0]  den,
	output atc_pkg::div_stat_t                  stat
);

	localparam int N     = atc_pkg::DIV_N_W;
	localparam int D     = atc_pkg::DIV_D_W;
	localparam int Q     = atc_pkg::QUO_W;
	localparam int CW    = $clog2(Q);
	localparam int CMP_W = N + D + Q;

	logic [N-1:0]  rem_q;
	logic [N-1:0]  dsh_q;
	logic [Q-1:0]  quo_q;
	logic [CW-1:0] cnt_q;
	logic          neg_q;
	logic          ovf_q;

	logic [N-1:0] nmag;
	logic [D-1:0] dmag;
	logic         ge;

	always_comb begin
		nmag = num[N-1] ? N'(-num) : N'(num);
		dmag = den[D-1] ? D'(-den) : D'(den);
		ge   = rem_q >= dsh_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.load) begin
			cnt_q <= CW'(Q - 1);
		end else if (ctl.step) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			rem_q <= nmag;
			dsh_q <= N'({dmag, {(Q - 1){1'b0}}});
			quo_q <= '0;
			neg_q <= num[N-1] ^ den[D-1];
			// quotient would not fit in Q bits
			ovf_q <= CMP_W'(nmag) >= CMP_W'({dmag, {Q{1'b0}}});
		end else if (ctl.step) begin
			if (ge) begin
				rem_q <= rem_q - dsh_q;
			end
			quo_q <= {quo_q[Q-2:0], ge};
			dsh_q <= dsh_q >> 1;
		end
	end

	always_comb begin
		stat.more = cnt_q != '0;
		stat.neg  = neg_q;
		stat.ovf  = ovf_q;
		stat.quo  = quo_q;
	end

endmodule

>>> rtl/accel_tilt_conditioner.sv
// channel  dir   handshake             payload
// in       sink  in_valid / in_ready   in_item  (req_type, raw_x/y/z, read_ok)
// out      src   out_valid / out_ready out_item (tilt_x/y, pitch_angle, calib_done)
// cfg      sink  cfg_we                cfg_idx, cfg_data (no wait, no read-back)
//
// One item at a time, run by a microcoded sequencer over a shared datapath.
// A pitch item skips the divide on a failed read or a zero z deviation, and a
// calibration sample divides only when it closes the set; an item taken while the
// sensor is not ready gets an all-zero result. Pitch and offset computation go
// through one divider at one quotient bit per cycle.
// Reset is asynchronous and takes effect at once; no clearing pass.
// A result waits in the output register while the next item is taken; the
// sequencer holds at its final step only if that register is still full.
module accel_tilt_conditioner #(
	parameter int CAL_SAMPLES = atc_pkg::CAL_SAMPLES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  atc_pkg::in_item_t                 in_item,
	output logic                              out_valid,
	input  logic                              out_ready,
	output atc_pkg::out_item_t                out_item,
	input  logic                              cfg_we,
	input  logic [atc_pkg::IDX_W-1:0]         cfg_idx,
	input  logic [atc_pkg::CFG_W-1:0]         cfg_data
);

	localparam int SUM_W = atc_pkg::RAW_W + $clog2(CAL_SAMPLES);
	localparam int CNT_W = $clog2(CAL_SAMPLES);
	localparam logic [CNT_W-1:0] CAL_LAST = CNT_W'(CAL_SAMPLES - 1);

	localparam int RAW_W   = atc_pkg::RAW_W;
	localparam int DEV_W   = atc_pkg::DEV_W;
	localparam int V_W     = atc_pkg::V_W;
	localparam int FILT_W  = atc_pkg::FILT_W;
	localparam int ACC_W   = atc_pkg::ACC_W;
	localparam int N_W     = atc_pkg::DIV_N_W;
	localparam int D_W     = atc_pkg::DIV_D_W;
	localparam int PC_W    = atc_pkg::PC_W;
	localparam int ALPHA_W = atc_pkg::ALPHA_W;

	// configuration
	logic                          sensor_ready_q;
	logic [atc_pkg::DZ_W-1:0]      dead_zone_q;
	logic [ALPHA_W-1:0]            alpha_q;
	logic                          flip_x_q;
	logic                          flip_y_q;
	logic [atc_pkg::LIM_W-1:0]     pitch_limit_q;

	// block state
	logic signed [RAW_W-1:0]  off_x_q, off_y_q, off_z_q;
	logic signed [SUM_W-1:0]  sum_x_q, sum_y_q, sum_z_q;
	logic [CNT_W-1:0]         cnt_q;
	logic signed [FILT_W-1:0] filt_x_q, filt_y_q;

	// sequencer and working registers
	logic [PC_W-1:0]          pc_q;
	atc_pkg::in_item_t        item_q;
	atc_pkg::out_item_t       res_q;
	atc_pkg::out_item_t       out_q;
	logic                     out_valid_q;
	logic signed [DEV_W-1:0]  dev_q, den_q;
	logic signed [V_W-1:0]    v_q;
	logic signed [ACC_W-1:0]  prod_q, acc_q;
	logic signed [N_W-1:0]    num_q;

	atc_pkg::cw_t       cw;
	atc_pkg::div_ctl_t  div_ctl;
	atc_pkg::div_stat_t div_stat;
	logic signed [N_W-1:0] div_num;
	logic signed [D_W-1:0] div_den;

	logic            accept;
	logic            emit;
	logic            hold;
	logic            take;
	logic [PC_W-1:0] entry;
	logic [PC_W-1:0] pc_d;

	logic signed [DEV_W-1:0]  dev_next, den_next;
	logic signed [DEV_W:0]    dz_in, dz_w, dz_t;
	logic signed [V_W-1:0]    v_next;
	logic [ALPHA_W-1:0]       a_sat, a_inv;
	logic signed [FILT_W-1:0] f_sel, f_next, t_full;
	logic signed [ACC_W-1:0]  prod_next, term, acc_next;
	logic signed [V_W-1:0]    t_val, t_next;
	logic [V_W-1:0]           q_wrap;
	logic signed [V_W-1:0]    off_next;
	logic [V_W-1:0]           lim16, p_mag;
	logic signed [V_W-1:0]    p_next;
	logic                     p_neg;

	assign cw = atc_pkg::ucode(pc_q);

	assign in_ready  = cw.op == atc_pkg::OP_WAIT;
	assign accept    = in_valid && in_ready;
	assign emit      = cw.op == atc_pkg::OP_EMIT && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// sequencer
	always_comb begin
		if (!sensor_ready_q) begin
			entry = atc_pkg::PC_EMIT;
		end else begin
			unique case (in_item.req_type)
				atc_pkg::REQ_CAL:   entry = atc_pkg::PC_CAL;
				atc_pkg::REQ_TILT:  entry = atc_pkg::PC_TILT;
				atc_pkg::REQ_PITCH: entry = atc_pkg::PC_PITCH;
				default:            entry = atc_pkg::PC_EMIT;
			endcase
		end

		unique case (cw.cond)
			atc_pkg::C_NEXT:       take = 1'b0;
			atc_pkg::C_ALWAYS:     take = 1'b1;
			atc_pkg::C_DISPATCH:   take = 1'b1;
			atc_pkg::C_DIV_MORE:   take = div_stat.more;
			atc_pkg::C_CAL_OPEN:   take = cnt_q != CAL_LAST;
			atc_pkg::C_PITCH_SKIP: take = !item_q.read_ok || den_q == '0;
			default:               take = 1'b0;
		endcase

		hold = (cw.op == atc_pkg::OP_WAIT && !in_valid) ||
			(cw.op == atc_pkg::OP_EMIT && !emit);

		if (hold) begin
			pc_d = pc_q;
		end else if (take) begin
			pc_d = (cw.cond == atc_pkg::C_DISPATCH) ? entry : cw.target;
		end else begin
			pc_d = pc_q + 1'b1;
		end
	end

	// divider operands
	always_comb begin
		div_ctl.load = cw.op == atc_pkg::OP_DIV_LOAD;
		div_ctl.step = cw.op == atc_pkg::OP_DIV_STEP;
		unique case (cw.sel)
			atc_pkg::SEL_X: div_num = N_W'(sum_x_q);
			atc_pkg::SEL_Y: div_num = N_W'(sum_y_q);
			atc_pkg::SEL_Z: div_num = N_W'(sum_z_q);
			atc_pkg::SEL_P: div_num = num_q;
		endcase
		div_den = (cw.sel == atc_pkg::SEL_P) ? den_q : D_W'(CAL_SAMPLES);
	end

	atc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (div_ctl),
		.num    (div_num),
		.den    (div_den),
		.stat   (div_stat)
	);

	// datapath
	always_comb begin
		// deviation from offset
		den_next = DEV_W'(item_q.raw_z) - DEV_W'(off_z_q);
		unique case (cw.sel)
			atc_pkg::SEL_Y: dev_next = item_q.read_ok ?
				DEV_W'(item_q.raw_y) - DEV_W'(off_y_q) : '0;
			atc_pkg::SEL_P: dev_next = DEV_W'(item_q.raw_x) - DEV_W'(off_x_q);
			atc_pkg::SEL_X,
			atc_pkg::SEL_Z: dev_next = item_q.read_ok ?
				DEV_W'(item_q.raw_x) - DEV_W'(off_x_q) : '0;
		endcase

		// dead zone, then clamp to 1 g
		dz_in = (DEV_W + 1)'(dev_q);
		dz_w  = $signed({3'b000, dead_zone_q});
		if (dz_in > dz_w) begin
			dz_t = dz_in - dz_w;
		end else if (dz_in < -dz_w) begin
			dz_t = dz_in + dz_w;
		end else begin
			dz_t = '0;
		end
		if (dz_t > atc_pkg::ONE_G) begin
			v_next = V_W'(atc_pkg::ONE_G);
		end else if (dz_t < -atc_pkg::ONE_G) begin
			v_next = -V_W'(atc_pkg::ONE_G);
		end else begin
			v_next = V_W'(dz_t);
		end

		// IIR, filter state in Q2
		a_sat = (alpha_q > ALPHA_W'(atc_pkg::ALPHA_ONE)) ?
			ALPHA_W'(atc_pkg::ALPHA_ONE) : alpha_q;
		a_inv = ALPHA_W'(atc_pkg::ALPHA_ONE) - a_sat;
		f_sel = (cw.sel == atc_pkg::SEL_Y) ? filt_y_q : filt_x_q;
		prod_next = ACC_W'(f_sel) * ACC_W'($signed({1'b0, a_inv}));
		term      = ACC_W'(v_q) * ACC_W'($signed({1'b0, a_sat}));
		acc_next  = prod_q + (term <<< atc_pkg::Q2_SHIFT);
		f_next    = FILT_W'((acc_q + ACC_W'(atc_pkg::Q8_HALF)) >>> atc_pkg::Q8_SHIFT);
		t_full    = (f_sel + FILT_W'(atc_pkg::Q2_HALF)) >>> atc_pkg::Q2_SHIFT;
		t_val     = V_W'(t_full);
		if (cw.sel == atc_pkg::SEL_Y) begin
			t_next = flip_y_q ? -t_val : t_val;
		end else begin
			t_next = flip_x_q ? -t_val : t_val;
		end

		// offset from the average; z loses 1 g
		q_wrap = div_stat.neg ? -div_stat.quo : div_stat.quo;
		if (cw.sel == atc_pkg::SEL_Z) begin
			off_next = $signed(q_wrap - V_W'(atc_pkg::ONE_G));
		end else begin
			off_next = $signed(q_wrap);
		end

		// pitch clamp on magnitude
		lim16  = {1'b0, pitch_limit_q};
		p_neg  = div_stat.neg ^ flip_x_q;
		p_mag  = (div_stat.ovf || div_stat.quo > lim16) ? lim16 : div_stat.quo;
		p_next = p_neg ? $signed(-p_mag) : $signed(p_mag);
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sensor_ready_q <= 1'b0;
			dead_zone_q    <= atc_pkg::DZ_RST;
			alpha_q        <= atc_pkg::ALPHA_RST;
			flip_x_q       <= 1'b1;
			flip_y_q       <= 1'b0;
			pitch_limit_q  <= atc_pkg::LIM_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				atc_pkg::REG_SENSOR_READY: sensor_ready_q <= cfg_data[0];
				atc_pkg::REG_DEAD_ZONE:    dead_zone_q    <= cfg_data[atc_pkg::DZ_W-1:0];
				atc_pkg::REG_SMOOTH_ALPHA: alpha_q        <= cfg_data[ALPHA_W-1:0];
				atc_pkg::REG_FLIP_X:       flip_x_q       <= cfg_data[0];
				atc_pkg::REG_FLIP_Y:       flip_y_q       <= cfg_data[0];
				atc_pkg::REG_PITCH_LIMIT:  pitch_limit_q  <= cfg_data[atc_pkg::LIM_W-1:0];
				default: ;
			endcase
		end
	end

	// control and block state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= atc_pkg::PC_IDLE;
			out_valid_q <= 1'b0;
			off_x_q     <= '0;
			off_y_q     <= '0;
			off_z_q     <= '0;
			sum_x_q     <= '0;
			sum_y_q     <= '0;
			sum_z_q     <= '0;
			cnt_q       <= '0;
			filt_x_q    <= '0;
			filt_y_q    <= '0;
		end else begin
			pc_q <= pc_d;

			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (cw.op == atc_pkg::OP_CAL_ACC) begin
				if (item_q.read_ok) begin
					sum_x_q <= sum_x_q + SUM_W'(item_q.raw_x);
					sum_y_q <= sum_y_q + SUM_W'(item_q.raw_y);
					sum_z_q <= sum_z_q + SUM_W'(item_q.raw_z);
				end
				cnt_q <= (cnt_q == CAL_LAST) ? '0 : cnt_q + 1'b1;
			end

			if (cw.op == atc_pkg::OP_SET_OFF) begin
				unique case (cw.sel)
					atc_pkg::SEL_X: off_x_q <= off_next;
					atc_pkg::SEL_Y: off_y_q <= off_next;
					atc_pkg::SEL_Z, atc_pkg::SEL_P: begin
						off_z_q <= off_next;
						sum_x_q <= '0;
						sum_y_q <= '0;
						sum_z_q <= '0;
					end
				endcase
			end

			if (cw.op == atc_pkg::OP_F_UPD) begin
				if (cw.sel == atc_pkg::SEL_Y) begin
					filt_y_q <= f_next;
				end else begin
					filt_x_q <= f_next;
				end
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= in_item;
			res_q  <= '0;
		end
		if (emit) begin
			out_q <= res_q;
		end
		unique case (cw.op)
			atc_pkg::OP_DEV: begin
				dev_q <= dev_next;
				den_q <= den_next;
			end
			atc_pkg::OP_DZ:      v_q    <= v_next;
			atc_pkg::OP_MUL_F:   prod_q <= prod_next;
			atc_pkg::OP_MUL_ACC: acc_q  <= acc_next;
			atc_pkg::OP_PMUL:    num_q  <= N_W'(dev_q) * N_W'(atc_pkg::PITCH_K);
			atc_pkg::OP_TILT_OUT: begin
				if (cw.sel == atc_pkg::SEL_Y) begin
					res_q.tilt_y <= t_next;
				end else begin
					res_q.tilt_x <= t_next;
				end
			end
			atc_pkg::OP_SET_OFF: begin
				if (cw.sel == atc_pkg::SEL_Z) begin
					res_q.calib_done <= 1'b1;
				end
			end
			atc_pkg::OP_PCLAMP:  res_q.pitch_angle <= p_next;
			default: ;
		endcase
	end

endmodule

>>> rtl/atc_checker.sv
module atc_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input atc_pkg::in_item_t     in_item,
	input logic                  out_valid,
	input logic                  out_ready,
	input atc_pkg::out_item_t    out_item
);

	// one item in flight: ready drops right after a transfer
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken on back-to-back cycles");

	// a result is either tilt or pitch, never both
	a_tilt_or_pitch: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.pitch_angle == 0 ||
			(out_item.tilt_x == 0 && out_item.tilt_y == 0))
		else $error("tilt and pitch both nonzero");

	// completing a calibration set carries no measurement
	a_calib_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.calib_done |-> out_item.tilt_x == 0 &&
			out_item.tilt_y == 0 && out_item.pitch_angle == 0)
		else $error("calibration result with nonzero fields");

	a_tilt_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.tilt_x <= 16384 && out_item.tilt_x >= -16384 &&
			out_item.tilt_y <= 16384 && out_item.tilt_y >= -16384)
		else $error("tilt outside 1 g");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result dropped or changed while stalled");

endmodule

bind accel_tilt_conditioner atc_checker u_atc_checker (.*);
